@@ src/dafd_pkg.sv @@
// Shared types, constants and delta tables for the delta audio frame decoder.
package dafd_pkg;

	// Width of the frame sample counter.
	localparam int unsigned LEN_W = 16;
	// Width of a per-command sample count (1..64).
	localparam int unsigned CNT_W = 7;
	// Width of the sample index inside one command (0..63).
	localparam int unsigned IDX_W = 6;
	// Depth of the command queue between front and back.
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW = $clog2(Q_DEPTH);

	// Predictor value at the start of a frame.
	localparam logic [7:0] PRED_INIT = 8'h80;

	// Code byte fields.
	localparam logic [1:0] CODE_SHORT  = 2'd0;
	localparam logic [1:0] CODE_NIB    = 2'd1;
	localparam logic [1:0] CODE_PAIR   = 2'd2;
	localparam logic [1:0] CODE_REPEAT = 2'd3;

	// Work items handed from the front to the back.
	typedef enum logic [2:0] {
		OP_LIT,
		OP_DELTA,
		OP_D4,
		OP_D2,
		OP_REP
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [7:0]       data;
		logic [CNT_W-1:0] n;
		logic             init;
		logic             last;
	} cmd_t;

	// Four-bit delta table.
	function automatic logic signed [4:0] tab4(input logic [3:0] code);
		logic signed [4:0] d;
		case (code)
			4'd0:    d = -5'sd9;
			4'd1:    d = -5'sd8;
			4'd2:    d = -5'sd6;
			4'd3:    d = -5'sd5;
			4'd4:    d = -5'sd4;
			4'd5:    d = -5'sd3;
			4'd6:    d = -5'sd2;
			4'd7:    d = -5'sd1;
			4'd8:    d = 5'sd0;
			4'd9:    d = 5'sd1;
			4'd10:   d = 5'sd2;
			4'd11:   d = 5'sd3;
			4'd12:   d = 5'sd4;
			4'd13:   d = 5'sd5;
			4'd14:   d = 5'sd6;
			default: d = 5'sd8;
		endcase
		return d;
	endfunction

	// Two-bit delta table.
	function automatic logic signed [4:0] tab2(input logic [1:0] code);
		logic signed [4:0] d;
		case (code)
			2'd0:    d = -5'sd2;
			2'd1:    d = -5'sd1;
			2'd2:    d = 5'sd0;
			default: d = 5'sd1;
		endcase
		return d;
	endfunction

	// Adds a small signed delta to a sample and clamps the result to 0..255.
	function automatic logic [7:0] sat_add(input logic [7:0] base, input logic signed [4:0] d);
		logic signed [9:0] sum;
		logic [7:0]        res;
		sum = $signed({2'b00, base}) + 10'(d);
		if (sum < 10'sd0) begin
			res = 8'd0;
		end else if (sum > 10'sd255) begin
			res = 8'd255;
		end else begin
			res = sum[7:0];
		end
		return res;
	endfunction

endpackage

@@ src/dafd_front.sv @@
// Front end: parses compressed bytes, tracks run and frame state, issues sample commands.
module dafd_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    acc,
	input  logic [7:0]              in_byte,
	input  logic                    frame_start,
	input  logic [15:0]             frame_length,
	output logic                    push,
	output dafd_pkg::cmd_t          cmd
);
	import dafd_pkg::*;

	typedef enum logic [1:0] {
		RM_CODE,
		RM_LIT,
		RM_NIB,
		RM_PAIR
	} run_t;

	run_t             mode_q;
	logic [CNT_W-1:0] rem_q;
	logic [LEN_W-1:0] left_q;
	logic             pend_q;

	run_t             md;
	logic [CNT_W-1:0] rm;
	logic [LEN_W-1:0] sl;
	logic [LEN_W-1:0] nsl;
	logic [CNT_W-1:0] cnt;
	logic [CNT_W-1:0] clipped;

	// Run length of a code (bytes, or samples for a repeat), and the same count cut to what the frame has left.
	assign cnt     = {1'b0, in_byte[5:0]} + CNT_W'(1);
	assign clipped = ({{(LEN_W-CNT_W){1'b0}}, cnt} > sl) ? sl[CNT_W-1:0] : cnt;

	// Decode one byte against the current run state.
	always_comb begin
		sl       = frame_start ? LEN_W'(frame_length) : left_q;
		md       = frame_start ? RM_CODE : mode_q;
		rm       = frame_start ? '0 : rem_q;
		push     = 1'b0;
		cmd.op   = OP_LIT;
		cmd.data = in_byte;
		cmd.n    = '0;
		cmd.init = pend_q | frame_start;
		cmd.last = 1'b0;
		if (sl != '0) begin
			// A delta byte that would overrun the frame is read as a code.
			if (md == RM_NIB && sl < LEN_W'(2)) begin
				md = RM_CODE;
			end
			if (md == RM_PAIR && sl < LEN_W'(4)) begin
				md = RM_CODE;
			end
			case (md)
				RM_LIT: begin
					push   = 1'b1;
					cmd.op = OP_LIT;
					cmd.n  = CNT_W'(1);
					rm     = rm - CNT_W'(1);
				end
				RM_NIB: begin
					push   = 1'b1;
					cmd.op = OP_D4;
					cmd.n  = CNT_W'(2);
					rm     = rm - CNT_W'(1);
				end
				RM_PAIR: begin
					push   = 1'b1;
					cmd.op = OP_D2;
					cmd.n  = CNT_W'(4);
					rm     = rm - CNT_W'(1);
				end
				default: begin
					case (in_byte[7:6])
						CODE_SHORT: begin
							if (in_byte[5]) begin
								push   = 1'b1;
								cmd.op = OP_DELTA;
								cmd.n  = CNT_W'(1);
							end else begin
								md = RM_LIT;
								rm = clipped;
							end
						end
						CODE_NIB: begin
							md = RM_NIB;
							rm = cnt;
						end
						CODE_PAIR: begin
							md = RM_PAIR;
							rm = cnt;
						end
						default: begin
							push   = 1'b1;
							cmd.op = OP_REP;
							cmd.n  = clipped;
						end
					endcase
				end
			endcase
		end
		nsl      = sl - {{(LEN_W-CNT_W){1'b0}}, cmd.n};
		cmd.last = (nsl == '0);
		// A finished run or frame returns to code parsing.
		if (rm == '0 || nsl == '0) begin
			md = RM_CODE;
			rm = '0;
		end
	end

	// Run and frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= RM_CODE;
			rem_q  <= '0;
			left_q <= '0;
			pend_q <= 1'b0;
		end else if (acc) begin
			mode_q <= md;
			rem_q  <= rm;
			left_q <= nsl;
			pend_q <= push ? 1'b0 : (pend_q | frame_start);
		end
	end

`ifndef NO_ASSERTIONS
	// Outside a frame no run may be pending.
	a_idle_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		(left_q == '0) |-> (mode_q == RM_CODE && rem_q == '0))
		else $error("run state left over outside a frame");
`endif

endmodule

@@ src/dafd_cmdq.sv @@
// Short command queue between the front end and the sample generator.
module dafd_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dafd_pkg::cmd_t wr_cmd,
	input  logic           pop,
	output dafd_pkg::cmd_t head,
	output logic           empty,
	output logic           full
);
	import dafd_pkg::*;

	cmd_t              mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_q;
	logic [Q_AW-1:0]   rd_q;
	logic [Q_AW:0]     cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign head  = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + Q_AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (Q_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (Q_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command queue read while empty");
`endif

endmodule

@@ src/dafd_back.sv @@
// Back end: runs queued commands one sample per cycle while the receiver does not stall, and holds the predictor.
module dafd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  dafd_pkg::cmd_t head,
	input  logic           empty,
	output logic           pop,
	input  logic           sample_stall,
	output logic           sample_valid,
	output logic [7:0]     sample,
	output logic           frame_end
);
	import dafd_pkg::*;

	logic [7:0]       pred_q;
	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	logic [7:0]       sample_q;
	logic             frame_end_q;

	logic             go;
	logic             last_smp;
	logic [7:0]       base;
	logic [7:0]       value;
	logic [3:0]       nib;
	logic [1:0]       pair;

	assign go       = !empty && (!valid_q || !sample_stall);
	assign last_smp = ({1'b0, idx_q} + CNT_W'(1)) == head.n;
	assign pop      = go && last_smp;
	assign base     = (head.init && idx_q == '0) ? PRED_INIT : pred_q;
	assign nib      = idx_q[0] ? head.data[7:4] : head.data[3:0];

	// Select the delta field for the current sample, low bits first.
	always_comb begin
		case (idx_q[1:0])
			2'd0:    pair = head.data[1:0];
			2'd1:    pair = head.data[3:2];
			2'd2:    pair = head.data[5:4];
			default: pair = head.data[7:6];
		endcase
	end

	// Next sample value.
	always_comb begin
		case (head.op)
			OP_LIT:   value = head.data;
			OP_DELTA: value = sat_add(base, $signed(head.data[4:0]));
			OP_D4:    value = sat_add(base, tab4(nib));
			OP_D2:    value = sat_add(base, tab2(pair));
			default:  value = base;
		endcase
	end

	// Predictor, sample index and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_q      <= PRED_INIT;
			idx_q       <= '0;
			valid_q     <= 1'b0;
			sample_q    <= '0;
			frame_end_q <= 1'b0;
		end else if (go) begin
			pred_q      <= value;
			sample_q    <= value;
			frame_end_q <= head.last && last_smp;
			idx_q       <= last_smp ? '0 : idx_q + IDX_W'(1);
			valid_q     <= 1'b1;
		end else if (!sample_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign sample_valid = valid_q;
	assign sample       = sample_q;
	assign frame_end    = frame_end_q;

`ifndef NO_ASSERTIONS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ({1'b0, idx_q} < head.n))
		else $error("sample index past command length");
	a_idx_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (idx_q == '0))
		else $error("sample index not cleared between commands");
`endif

endmodule

@@ src/delta_audio_frame_decoder.sv @@
// Top level of the delta audio frame decoder.
//
// Input channel: one compressed byte per request on in_byte, with frame_start
// marking the first byte of a frame and frame_length giving its sample count.
// A byte is taken when byte_valid is high and byte_stall is low.
// Output channel: one decoded 8-bit sample per request on sample, with
// frame_end high on the last sample of the frame; taken when sample_valid is
// high and sample_stall is low.
// The front end parses one byte per cycle, while the queue is not full, into
// sample commands and pushes them into a four-entry queue; the back end turns
// the head command into one sample per cycle while the receiver does not stall.
// The first sample of a byte passes through the queue and the output register
// after the byte is taken. Throughput is one sample per cycle, set by the back
// end's single sample path; a byte yields 0, 1, 2, 4 or up to 64 samples, and
// byte_stall rises while the queue is full.
// Reset clears the queue, the run state and the frame count and sets the
// predictor to 128; bytes arriving outside a frame yield nothing. When the
// receiver stalls, the held sample stays put and the queue fills behind it.
module delta_audio_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  in_byte,
	input  logic        frame_start,
	input  logic [15:0] frame_length,
	output logic        sample_valid,
	input  logic        sample_stall,
	output logic [7:0]  sample,
	output logic        frame_end
);
	import dafd_pkg::*;

	logic acc;
	logic push;
	logic pop;
	logic empty;
	logic full;
	cmd_t wr_cmd;
	cmd_t head;

	assign byte_stall = full;
	assign acc        = byte_valid && !full;

	dafd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.in_byte      (in_byte),
		.frame_start  (frame_start),
		.frame_length (frame_length),
		.push         (push),
		.cmd          (wr_cmd)
	);

	dafd_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && acc),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	dafd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.sample_stall (sample_stall),
		.sample_valid (sample_valid),
		.sample       (sample),
		.frame_end    (frame_end)
	);

endmodule
